// File: rtl/wmv_pkg.sv
// Package for the weighted moving variance background subtractor.
// Holds frame geometry, register addresses and beat structs; no dependencies.
`default_nettype none
package wmv_pkg;
  localparam int FRAME_PIXELS = 307200;
  localparam int POS_W = $clog2(FRAME_PIXELS);
  localparam logic [3:0] ADDR_WEIGHTED = 4'd0;
  localparam logic [3:0] ADDR_THR_EN = 4'd4;
  localparam logic [3:0] ADDR_THR_LVL = 4'd8;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_in_frame;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       warming_up;
    logic       end_of_frame;
  } out_beat_t;
endpackage
`default_nettype wire

// File: rtl/wmv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module wmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/wmv_root.sv
// Pipelined rounded square root: out = largest r with 250*(2r-1)^2 <= q.
// Eight restoring stages, one result bit each; uses wmv_pkg nothing.
`default_nettype none
module wmv_root (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [27:0] q,
  output logic      [7:0]  root
);
  logic [27:0] q_r [9];
  logic [7:0]  r_r [9];
  always_comb begin
    q_r[0] = q;
    r_r[0] = '0;
  end
  for (genvar s = 0; s < 8; s++) begin : g_st
    logic [7:0]  cand;
    logic [8:0]  t;
    logic [35:0] lhs;
    always_comb begin
      cand = r_r[s] | (8'd1 << (7 - s));
      t    = {cand, 1'b0} - 9'd1;
      lhs  = 36'd250 * {27'd0, t} * {27'd0, t};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1] <= q_r[s];
        r_r[s+1] <= (lhs <= {8'd0, q_r[s]}) ? cand : r_r[s];
      end
    end
  end
  assign root = r_r[8];
endmodule
`default_nettype wire

// File: rtl/weighted_moving_variance_bgs_top.sv
// Top level of the weighted moving variance background subtractor.
// Uses wmv_pkg, wmv_ram and wmv_root.
// A beat accepted at the input passes through 14 register stages to the output;
// throughput one pixel per cycle whenever the output is not stalled, as the whole pipe
// advances together. Synchronous active-low reset clears valids, position, frame count
// and configuration registers; history memories are not cleared.
`default_nettype none
module weighted_moving_variance_bgs_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wmv_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output wmv_pkg::out_beat_t     out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [3:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);
  localparam int PW = wmv_pkg::POS_W;
  localparam int NS = 14;

  logic wmode_r, thr_en_r;
  logic [7:0] thr_lvl_r;
  logic wr;
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmode_r <= 1'b1; thr_en_r <= 1'b0; thr_lvl_r <= '0;
    end else if (wr) begin
      case (cfg_paddr)
        wmv_pkg::ADDR_WEIGHTED: wmode_r <= cfg_pwdata[0];
        wmv_pkg::ADDR_THR_EN: thr_en_r <= cfg_pwdata[0];
        wmv_pkg::ADDR_THR_LVL: thr_lvl_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr)
      wmv_pkg::ADDR_WEIGHTED: cfg_prdata = {31'd0, wmode_r};
      wmv_pkg::ADDR_THR_EN: cfg_prdata = {31'd0, thr_en_r};
      wmv_pkg::ADDR_THR_LVL: cfg_prdata = {24'd0, thr_lvl_r};
      default: cfg_prdata = '0;
    endcase
  end

  logic adv, acc;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc = in_valid && adv;

  logic [PW-1:0] pos_r;
  logic [1:0] frames_r;
  logic wrap;
  assign wrap = in_data.last_in_frame || ({1'b0, pos_r} + 1'b1 >= (PW+1)'(wmv_pkg::FRAME_PIXELS));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; frames_r <= '0;
    end else if (acc) begin
      pos_r <= wrap ? '0 : pos_r + 1'b1;
      if (wrap && frames_r != 2'd2) frames_r <= frames_r + 1'b1;
    end
  end

  // stage 1: memory read issued; stage 2: data available
  logic [NS:1] v_r;
  logic [7:0] px1_r, px2_r;
  logic last1_r, last2_r, warm1_r, warm2_r, h2w1_r;
  logic [PW-1:0] pos1_r;
  logic [7:0] h1_q, h2_q;
  logic fwd_r;
  logic [7:0] fwd_d_r;

  wmv_ram #(.WIDTH(8), .DEPTH(wmv_pkg::FRAME_PIXELS)) u_h1 (
    .clk(clk), .we(acc), .waddr(pos_r), .wdata(in_data.pixel),
    .re(acc), .raddr(pos_r), .rdata(h1_q));
  wmv_ram #(.WIDTH(8), .DEPTH(wmv_pkg::FRAME_PIXELS)) u_h2 (
    .clk(clk), .we(adv && v_r[1] && h2w1_r), .waddr(pos1_r), .wdata(h1_q),
    .re(acc), .raddr(pos_r), .rdata(h2_q));

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NS-1:1], in_valid};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      px1_r <= in_data.pixel; last1_r <= in_data.last_in_frame;
      warm1_r <= frames_r != 2'd2; h2w1_r <= frames_r != 2'd0; pos1_r <= pos_r;
      px2_r <= px1_r; last2_r <= last1_r; warm2_r <= warm1_r;
      // forward the history_two write that lands at the same edge as this read
      fwd_r <= v_r[1] && h2w1_r && (pos1_r == pos_r);
      fwd_d_r <= h1_q;
    end
  end
  logic [7:0] x1_r, x2_r;
  always_ff @(posedge clk) if (adv) begin
    x1_r <= h1_q;
    x2_r <= fwd_r ? fwd_d_r : h2_q;
  end

  // stage 3: S
  logic [3:0] w0, w2;
  logic [11:0] s3_r;
  logic [7:0] px3_r, x13_r, x23_r;
  logic last3_r, warm3_r, wm3_r;
  assign w0 = wmode_r ? 4'd5 : 4'd3;
  assign w2 = wmode_r ? 4'd2 : 4'd3;
  always_ff @(posedge clk) if (adv) begin
    s3_r <= 12'(px2_r) * 12'(w0) + 12'(x1_r) * 12'd3 + 12'(x2_r) * 12'(w2);
    px3_r <= px2_r; x13_r <= x1_r; x23_r <= x2_r;
    last3_r <= last2_r; warm3_r <= warm2_r; wm3_r <= wmode_r;
  end
  // stage 4: deviations
  logic signed [12:0] d0_r, d1_r, d2_r;
  logic [7:0] px4_r; logic last4_r, warm4_r, wm4_r;
  always_ff @(posedge clk) if (adv) begin
    d0_r <= $signed({1'b0, 12'(px3_r) * 12'd10}) - $signed({1'b0, s3_r});
    d1_r <= $signed({1'b0, 12'(x13_r) * 12'd10}) - $signed({1'b0, s3_r});
    d2_r <= $signed({1'b0, 12'(x23_r) * 12'd10}) - $signed({1'b0, s3_r});
    px4_r <= px3_r; last4_r <= last3_r; warm4_r <= warm3_r; wm4_r <= wm3_r;
  end
  // stage 5: squares
  logic [23:0] sq0_r, sq1_r, sq2_r;
  logic [7:0] px5_r; logic last5_r, warm5_r, wm5_r;
  logic signed [23:0] e0, e1, e2;
  always_comb begin
    e0 = 24'(d0_r);
    e1 = 24'(d1_r);
    e2 = 24'(d2_r);
  end
  always_ff @(posedge clk) if (adv) begin
    sq0_r <= $unsigned(e0 * e0); sq1_r <= $unsigned(e1 * e1); sq2_r <= $unsigned(e2 * e2);
    px5_r <= px4_r; last5_r <= last4_r; warm5_r <= warm4_r; wm5_r <= wm4_r;
  end
  // stage 6: weighted sum
  logic [27:0] q6_r;
  logic [7:0] pxd_r [7:14];
  logic lastd_r [6:14];
  logic warmd_r [6:14];
  logic [7:0] px6_r;
  always_ff @(posedge clk) if (adv) begin
    q6_r <= 28'(sq0_r) * (wm5_r ? 28'd5 : 28'd3) + 28'(sq1_r) * 28'd3
          + 28'(sq2_r) * (wm5_r ? 28'd2 : 28'd3);
    px6_r <= px5_r; lastd_r[6] <= last5_r; warmd_r[6] <= warm5_r;
  end
  // stages 7..14: root
  logic [7:0] root;
  wmv_root u_root (.clk(clk), .en(adv), .q(q6_r), .root(root));
  always_ff @(posedge clk) if (adv) begin
    pxd_r[7] <= px6_r;
    for (int i = 8; i <= NS; i++) pxd_r[i] <= pxd_r[i-1];
    for (int i = 7; i <= NS; i++) begin
      lastd_r[i] <= lastd_r[i-1]; warmd_r[i] <= warmd_r[i-1];
    end
  end
  logic [7:0] dev;
  always_comb begin
    dev = root;
    if (thr_en_r) dev = (root > thr_lvl_r) ? 8'hFF : 8'h00;
  end
  assign out_valid = v_r[NS];
  assign out_data.out_pixel = warmd_r[NS] ? pxd_r[NS] : dev;
  assign out_data.warming_up = warmd_r[NS];
  assign out_data.end_of_frame = lastd_r[NS];
endmodule
`default_nettype wire

// File: rtl/wmv_checker.sv
// Port-level checker for the background subtractor, bound to the top level.
// Uses wmv_pkg beat types.
`default_nettype none
module wmv_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire wmv_pkg::out_beat_t out_data
);
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("stall without full output");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("output beat changed under stall");
  a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({out_valid, in_stall}))
    else $error("unknown handshake");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst_n) == 1'b0 |-> !out_valid) else $error("valid after reset");
endmodule

bind weighted_moving_variance_bgs_top wmv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire

// File: tb/sv/weighted_moving_variance_bgs_checker.sv
// Scoreboard for the weighted moving variance background subtractor.
// Snoops the pixel, result and register channels, predicts each result beat
// and compares it field by field; depends on wmv_pkg only.
module weighted_moving_variance_bgs_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  wmv_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  wmv_pkg::out_beat_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output int                 pending,
  output int                 fails,
  output int                 checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]          prior_frame [wmv_pkg::FRAME_PIXELS];
  logic [7:0]          older_frame [wmv_pkg::FRAME_PIXELS];
  int                  frames_done;
  int                  pix_index;
  bit                  weighted;
  bit                  mask_on;
  logic [7:0]          mask_level;
  wmv_pkg::out_beat_t  predicted_pixels[$];

  function automatic logic [7:0] rounded_root(longint q);
    int r;
    longint t;
    r = 0;
    for (int k = 1; k <= 255; k++) begin
      t = 2 * k - 1;
      if (250 * t * t <= q) r = k;
      else break;
    end
    return r[7:0];
  endfunction

  function automatic logic [7:0] spread(longint x0, longint x1, longint x2);
    longint w0, w2, s, d0, d1, d2;
    w0 = weighted ? 5 : 3;
    w2 = weighted ? 2 : 3;
    s = w0 * x0 + 3 * x1 + w2 * x2;
    d0 = 10 * x0 - s;
    d1 = 10 * x1 - s;
    d2 = 10 * x2 - s;
    return rounded_root(w0 * d0 * d0 + 3 * d1 * d1 + w2 * d2 * d2);
  endfunction

  function automatic wmv_pkg::out_beat_t predict_pixel(wmv_pkg::in_beat_t b);
    wmv_pkg::out_beat_t r;
    int p;
    p = (pix_index >= wmv_pkg::FRAME_PIXELS) ? 0 : pix_index;
    if (frames_done >= 2) begin
      r.warming_up = 1'b0;
      r.out_pixel = spread(b.pixel, prior_frame[p], older_frame[p]);
      if (mask_on) r.out_pixel = (r.out_pixel > mask_level) ? 8'd255 : 8'd0;
    end else begin
      r.warming_up = 1'b1;
      r.out_pixel = b.pixel;
    end
    r.end_of_frame = b.last_in_frame;
    if (frames_done >= 1) older_frame[p] = prior_frame[p];
    prior_frame[p] = b.pixel;
    if (b.last_in_frame || p + 1 >= wmv_pkg::FRAME_PIXELS) begin
      pix_index = 0;
      if (frames_done < 2) frames_done++;
    end else begin
      pix_index = p + 1;
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    checked = 0;
  end

  assign pending = predicted_pixels.size();

  always @(posedge clk) begin
    wmv_pkg::out_beat_t e;
    if (!rst_n) begin
      predicted_pixels.delete();
      frames_done = 0;
      pix_index = 0;
      weighted = 1'b1;
      mask_on = 1'b0;
      mask_level = 8'd0;
    end else begin
      if (in_valid && !in_stall) predicted_pixels.push_back(predict_pixel(in_data));
      if (out_valid && !out_stall) begin
        if (predicted_pixels.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          e = predicted_pixels.pop_front();
          checked++;
          if (out_data.out_pixel !== e.out_pixel)
            report("out_pixel", out_data.out_pixel, e.out_pixel);
          if (out_data.warming_up !== e.warming_up)
            report("warming_up", out_data.warming_up, e.warming_up);
          if (out_data.end_of_frame !== e.end_of_frame)
            report("end_of_frame", out_data.end_of_frame, e.end_of_frame);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          wmv_pkg::ADDR_WEIGHTED: weighted = cfg_pwdata[0];
          wmv_pkg::ADDR_THR_EN:   mask_on = cfg_pwdata[0];
          wmv_pkg::ADDR_THR_LVL:  mask_level = cfg_pwdata[7:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/sv/weighted_moving_variance_bgs_top_tb.sv
// Testbench top for the weighted moving variance background subtractor.
// Drives pixel frames and register writes, instantiates the block and the
// scoreboard in weighted_moving_variance_bgs_checker.sv; depends on wmv_pkg.
module weighted_moving_variance_bgs_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2000000;
  localparam int MAX_LEN = 8;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  wmv_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  wmv_pkg::out_beat_t out_data;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [3:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int                 pending;
  int                 fails;
  int                 checked;
  int                 cycles;
  int                 tx_idle;
  int                 rx_idle;
  int                 sent;
  logic [7:0]         scene [MAX_LEN];

  weighted_moving_variance_bgs_top dut (.*);

  weighted_moving_variance_bgs_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .cfg_psel(cfg_psel), .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite), .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .pending(pending), .fails(fails), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle);
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] px, logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel: px, last_in_frame: last};
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [31:0] val);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic random_frame(int len);
    logic [7:0] px;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: px = 8'($urandom_range(255));
        1: px = scene[i];
        default: px = scene[i] + 8'($urandom_range(30)) - 8'd15;
      endcase
      if ($urandom_range(7) == 0) scene[i] = px;
      send_pixel(px, i == len - 1);
    end
  endtask

  task automatic random_block(int items);
    int n;
    n = 0;
    while (n < items) begin
      random_frame($urandom_range(1, MAX_LEN));
      n += 1;
      if ($urandom_range(40) == 0) drain();
    end
  endtask

  initial begin
    logic [7:0] warm [MAX_LEN] = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd127, 8'd0, 8'd255};
    cycles = 0;
    sent = 0;
    tx_idle = 32;
    rx_idle = 78;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (warm[i]) send_pixel(warm[i], i == MAX_LEN - 1);
    foreach (warm[i]) send_pixel(8'd255 - warm[i], i == MAX_LEN - 1);
    foreach (warm[i]) send_pixel(warm[(i + 3) % MAX_LEN], i == MAX_LEN - 1);
    foreach (scene[i]) scene[i] = 8'($urandom_range(255));
    write_reg(wmv_pkg::ADDR_WEIGHTED, 32'd0);
    write_reg(wmv_pkg::ADDR_THR_EN, 32'd1);
    write_reg(wmv_pkg::ADDR_THR_LVL, 32'd0);
    send_pixel(8'd255, 1'b1);
    write_reg(wmv_pkg::ADDR_THR_LVL, 32'd255);
    send_pixel(8'd0, 1'b1);

    write_reg(wmv_pkg::ADDR_THR_EN, 32'd0);
    random_block(70);
    write_reg(wmv_pkg::ADDR_WEIGHTED, 32'd1);
    random_block(70);
    tx_idle = 78;
    rx_idle = 32;
    write_reg(wmv_pkg::ADDR_THR_EN, 32'd1);
    write_reg(wmv_pkg::ADDR_THR_LVL, $urandom_range(1, 40));
    random_block(70);
    write_reg(wmv_pkg::ADDR_WEIGHTED, 32'd0);
    random_block(70);
    tx_idle = 0;
    rx_idle = 0;
    write_reg(wmv_pkg::ADDR_THR_LVL, 32'd255);
    random_block(72);
    write_reg(wmv_pkg::ADDR_THR_EN, 32'd0);
    write_reg(wmv_pkg::ADDR_WEIGHTED, 32'd1);
    random_block(72);
    random_frame(MAX_LEN);
    random_frame(3);

    drain();
    $display("Sent %0d pixels, %0d result beats checked, across both weightings,", sent, checked);
    $display("mask levels 0 and 255, short frames and three idle profiles.");
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/wmv_pkg.sv
rtl/wmv_ram.sv
rtl/wmv_root.sv
rtl/weighted_moving_variance_bgs_top.sv
rtl/wmv_checker.sv
tb/sv/weighted_moving_variance_bgs_checker.sv
tb/sv/weighted_moving_variance_bgs_top_tb.sv
